[sv/ttd_pkg.sv]
// Shared constants and types for the touch tap detector.
package ttd_pkg;

    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 16;
    localparam int DRIFT_W = 13;
    localparam int COORD_W = 12;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [DRIFT_W-1:0] drift_t;
    typedef logic [HOLD_W-1:0]  hold_t;
    typedef logic [TIME_W-1:0]  time_t;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_HOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIFT = 2'd2;

    localparam hold_t  RST_MIN_HOLD  = 16'd15;
    localparam hold_t  RST_MAX_HOLD  = 16'd700;
    localparam drift_t RST_MAX_DRIFT = 13'd40;

    localparam logic [3:0] TOUCH_MASK = 4'hF;

endpackage

[sv/ttd_poll_if.sv]
// Poll channel: one controller poll per transaction.
interface ttd_poll_if
    import ttd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ms;
    logic              status_ok;
    logic [BYTE_W-1:0] status_byte;
    logic              point_ok;
    logic [BYTE_W-1:0] x_high;
    logic [BYTE_W-1:0] x_low;
    logic [BYTE_W-1:0] y_high;
    logic [BYTE_W-1:0] y_low;

    modport source (
        output valid, now_ms, status_ok, status_byte, point_ok,
               x_high, x_low, y_high, y_low,
        input  ready
    );

    modport sink (
        input  valid, now_ms, status_ok, status_byte, point_ok,
               x_high, x_low, y_high, y_low,
        output ready
    );
endinterface

[sv/ttd_result_if.sv]
// Result channel: one tap/pressed report per transaction.
interface ttd_result_if
    import ttd_pkg::*;
();
    logic valid;
    logic ready;
    logic tap;
    logic pressed;

    modport source (
        output valid, tap, pressed,
        input  ready
    );

    modport sink (
        input  valid, tap, pressed,
        output ready
    );
endinterface

[sv/ttd_drift.sv]
// Bit-serial drift unit: dx*dx + dy*dy by shift-add, then a rounded bit-by-bit square root.
module ttd_drift
    import ttd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  coord_t dx,
    input  coord_t dy,
    output logic   done,
    output drift_t drift
);

    localparam logic [1:0] P_IDLE  = 2'd0;
    localparam logic [1:0] P_MUL   = 2'd1;
    localparam logic [1:0] P_ROOT  = 2'd2;
    localparam logic [1:0] P_ROUND = 2'd3;

    localparam int RAD_W = 2 * DRIFT_W;
    localparam int REM_W = DRIFT_W + 3;
    localparam logic [3:0] MUL_LAST  = 4'(COORD_W - 1);
    localparam logic [3:0] ROOT_LAST = 4'(DRIFT_W - 1);

    logic [1:0]       phase_reg, phase_next;
    logic [3:0]       cnt_reg, cnt_next;
    coord_t           dx_reg, dx_next;
    coord_t           dy_reg, dy_next;
    coord_t           mx_reg, mx_next;
    coord_t           my_reg, my_next;
    logic [RAD_W-1:0] acc_reg, acc_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    drift_t           root_reg, root_next;
    logic             done_reg, done_next;
    drift_t           drift_reg, drift_next;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        drift_next = drift_reg;
        rem_shift  = {rem_reg[REM_W-3:0], acc_reg[RAD_W-1 -: 2]};
        trial      = {1'b0, root_reg, 2'b01};

        case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    dx_next    = dx;
                    dy_next    = dy;
                    mx_next    = dx;
                    my_next    = dy;
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = P_MUL;
                end
            end
            P_MUL:
            begin
                acc_next = {acc_reg[RAD_W-2:0], 1'b0}
                         + (mx_reg[COORD_W-1] ? RAD_W'(dx_reg) : '0)
                         + (my_reg[COORD_W-1] ? RAD_W'(dy_reg) : '0);
                mx_next  = {mx_reg[COORD_W-2:0], 1'b0};
                my_next  = {my_reg[COORD_W-2:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    phase_next = P_ROOT;
                end
            end
            P_ROOT:
            begin
                if (rem_shift >= trial)
                begin
                    rem_next  = rem_shift - trial;
                    root_next = {root_reg[DRIFT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    root_next = {root_reg[DRIFT_W-2:0], 1'b0};
                end
                acc_next = {acc_reg[RAD_W-3:0], 2'b00};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == ROOT_LAST)
                begin
                    phase_next = P_ROUND;
                end
            end
            P_ROUND:
            begin
                // Round half up: the remainder exceeds the root exactly when s > r*r + r.
                drift_next = root_reg + ((rem_reg > REM_W'(root_reg)) ? 13'd1 : 13'd0);
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        drift_reg <= drift_next;
    end

    assign done  = done_reg;
    assign drift = drift_reg;

endmodule

[sv/touch_tap_detector_core.sv]
// Touch tap detector: press tracking, peak drift and tap qualification.
//
//  Channel   Direction  Transaction
//  poll      in         one controller poll (time, status, one point)
//  result    out        tap and pressed flags for that poll
//  cfg_*     in         register write, no handshake
//
// A poll that reports a held point holds off the next poll while the drift
// unit runs its shift-add squaring, square-root digits and rounding, and
// the peak is updated. Every other poll leaves the core ready for the next.
// Its result is loaded into the output register at acceptance, so a stalled
// result only holds off polls while that register is still full.
// Reset clears the press state, the peak drift and the registers to defaults.
module touch_tap_detector_core
    import ttd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    ttd_poll_if.sink              poll,
    ttd_result_if.source          result
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    hold_t  min_hold_reg, min_hold_next;
    hold_t  max_hold_reg, max_hold_next;
    drift_t max_drift_reg, max_drift_next;

    logic   state_reg, state_next;
    logic   contact_reg, contact_next;
    coord_t start_x_reg, start_x_next;
    coord_t start_y_reg, start_y_next;
    drift_t peak_reg, peak_next;
    time_t  press_time_reg, press_time_next;

    logic   out_valid_reg, out_valid_next;
    logic   out_tap_reg, out_tap_next;
    logic   out_pressed_reg, out_pressed_next;

    logic   accept;
    logic   touching;
    coord_t px;
    coord_t py;
    coord_t dx;
    coord_t dy;
    time_t  held;
    logic   qualifies;
    logic   drift_start;
    logic   drift_done;
    drift_t drift;

    assign poll.ready = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign accept     = poll.valid && poll.ready;
    assign touching   = (poll.status_byte[3:0] & TOUCH_MASK) != 4'd0;
    assign px         = {poll.x_high[3:0], poll.x_low};
    assign py         = {poll.y_high[3:0], poll.y_low};
    assign dx         = (px >= start_x_reg) ? px - start_x_reg : start_x_reg - px;
    assign dy         = (py >= start_y_reg) ? py - start_y_reg : start_y_reg - py;
    assign held       = poll.now_ms - press_time_reg;
    assign qualifies  = (held >= TIME_W'(min_hold_reg)) && (held <= TIME_W'(max_hold_reg))
                      && (peak_reg <= max_drift_reg);

    assign drift_start = accept && poll.status_ok && contact_reg && touching && poll.point_ok;

    ttd_drift u_drift (
        .clk   (clk),
        .rst_n (rst_n),
        .start (drift_start),
        .dx    (dx),
        .dy    (dy),
        .done  (drift_done),
        .drift (drift)
    );

    always_comb
    begin
        min_hold_next  = min_hold_reg;
        max_hold_next  = max_hold_reg;
        max_drift_next = max_drift_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_HOLD:  min_hold_next  = cfg_wdata[HOLD_W-1:0];
                REG_MAX_HOLD:  max_hold_next  = cfg_wdata[HOLD_W-1:0];
                REG_MAX_DRIFT: max_drift_next = cfg_wdata[DRIFT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        contact_next     = contact_reg;
        start_x_next     = start_x_reg;
        start_y_next     = start_y_reg;
        peak_next        = peak_reg;
        press_time_next  = press_time_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_tap_next     = out_tap_reg;
        out_pressed_next = out_pressed_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next   = 1'b1;
                    out_tap_next     = 1'b0;
                    out_pressed_next = contact_reg;
                    if (poll.status_ok)
                    begin
                        if (!contact_reg)
                        begin
                            if (touching && poll.point_ok)
                            begin
                                start_x_next     = px;
                                start_y_next     = py;
                                peak_next        = '0;
                                press_time_next  = poll.now_ms;
                                contact_next     = 1'b1;
                                out_pressed_next = 1'b1;
                            end
                        end
                        else if (touching)
                        begin
                            if (poll.point_ok)
                            begin
                                state_next = S_BUSY;
                            end
                        end
                        else
                        begin
                            contact_next     = 1'b0;
                            out_pressed_next = 1'b0;
                            out_tap_next     = qualifies;
                        end
                    end
                end
            end
            S_BUSY:
            begin
                if (drift_done)
                begin
                    if (drift > peak_reg)
                    begin
                        peak_next = drift;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_hold_reg  <= RST_MIN_HOLD;
            max_hold_reg  <= RST_MAX_HOLD;
            max_drift_reg <= RST_MAX_DRIFT;
            state_reg     <= S_IDLE;
            contact_reg   <= 1'b0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_hold_reg  <= min_hold_next;
            max_hold_reg  <= max_hold_next;
            max_drift_reg <= max_drift_next;
            state_reg     <= state_next;
            contact_reg   <= contact_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_x_reg     <= start_x_next;
        start_y_reg     <= start_y_next;
        press_time_reg  <= press_time_next;
        out_tap_reg     <= out_tap_next;
        out_pressed_reg <= out_pressed_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.tap     = out_tap_reg;
    assign result.pressed = out_pressed_reg;

endmodule

[sim/tb_touch_tap_detector_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the touch tap detector core against a tap predictor.
module tb_touch_tap_detector_core
    import ttd_pkg::*;
();

    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int IDLE_PERCENT   = 33;
    localparam int SHOW_LIMIT     = 10;
    localparam int COORD_MAX      = (1 << COORD_W) - 1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        time_t             now;
        logic              status_ok;
        logic [BYTE_W-1:0] status;
        logic              point_ok;
        logic [BYTE_W-1:0] x_high;
        logic [BYTE_W-1:0] x_low;
        logic [BYTE_W-1:0] y_high;
        logic [BYTE_W-1:0] y_low;
    } poll_t;

    typedef struct packed {
        logic tap;
        logic pressed;
    } tap_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ttd_poll_if   poll_ch();
    ttd_result_if report_ch();

    touch_tap_detector_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .poll      (poll_ch),
        .result    (report_ch)
    );

    hold_t  min_hold    = RST_MIN_HOLD;
    hold_t  max_hold    = RST_MAX_HOLD;
    drift_t drift_limit = RST_MAX_DRIFT;
    logic   in_contact  = 1'b0;
    coord_t start_x     = '0;
    coord_t start_y     = '0;
    drift_t peak_drift  = '0;
    time_t  press_time  = '0;

    tap_report_t report_q[$];
    int          errors        = 0;
    int          sink_hold_req = 0;
    bit          src_idle_en   = 1'b1;
    bit          sink_idle_en  = 1'b1;
    time_t       clock_ms      = '0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic drift_t rounded_distance(input coord_t ax, input coord_t ay,
                                                input coord_t bx, input coord_t by);
        logic [31:0]        dx;
        logic [31:0]        dy;
        logic [31:0]        sq;
        logic [DRIFT_W-1:0] root;
        logic [DRIFT_W-1:0] trial;
        dx = (ax >= bx) ? 32'(ax) - 32'(bx) : 32'(bx) - 32'(ax);
        dy = (ay >= by) ? 32'(ay) - 32'(by) : 32'(by) - 32'(ay);
        sq = dx * dx + dy * dy;
        root = '0;
        for (int b = DRIFT_W - 1; b >= 0; b--)
        begin
            trial = root | (13'd1 << b);
            if (32'(trial) * 32'(trial) <= sq)
                root = trial;
        end
        if (sq - 32'(root) * 32'(root) > 32'(root))
            root = root + 1'b1;
        return root;
    endfunction

    function automatic tap_report_t predict_poll(input poll_t p);
        logic        touching;
        coord_t      px;
        coord_t      py;
        drift_t      d;
        time_t       held;
        tap_report_t r;
        touching = (p.status[3:0] & TOUCH_MASK) != 4'h0;
        px = {p.x_high[3:0], p.x_low};
        py = {p.y_high[3:0], p.y_low};
        r.tap = 1'b0;
        if (p.status_ok)
        begin
            if (!in_contact)
            begin
                if (touching && p.point_ok)
                begin
                    start_x    = px;
                    start_y    = py;
                    peak_drift = '0;
                    press_time = p.now;
                    in_contact = 1'b1;
                end
            end
            else if (touching)
            begin
                if (p.point_ok)
                begin
                    d = rounded_distance(px, py, start_x, start_y);
                    if (d > peak_drift)
                        peak_drift = d;
                end
            end
            else
            begin
                held       = p.now - press_time;
                in_contact = 1'b0;
                r.tap      = held >= 32'(min_hold) && held <= 32'(max_hold) &&
                             peak_drift <= drift_limit;
            end
        end
        r.pressed = in_contact;
        return r;
    endfunction

    function automatic poll_t make_poll(input time_t t, input logic sok, input logic [7:0] st,
                                        input logic pok, input coord_t x, input coord_t y);
        poll_t p;
        p.now       = t;
        p.status_ok = sok;
        p.status    = st;
        p.point_ok  = pok;
        p.x_high    = {4'($urandom), x[11:8]};
        p.x_low     = x[7:0];
        p.y_high    = {4'($urandom), y[11:8]};
        p.y_low     = y[7:0];
        return p;
    endfunction

    function automatic logic [7:0] touch_status();
        return {4'($urandom), 4'($urandom_range(1, 15))};
    endfunction

    function automatic logic [7:0] lift_status();
        return {4'($urandom), 4'h0};
    endfunction

    function automatic coord_t nudge(input coord_t c, input int rad);
        int v;
        v = int'(c) + int'($urandom_range(2 * rad)) - rad;
        if (v < 0)
            v = 0;
        else if (v > COORD_MAX)
            v = COORD_MAX;
        return coord_t'(v);
    endfunction

    function automatic time_t pick_hold();
        case ($urandom_range(9))
            0: return time_t'(min_hold) - 1;
            1: return time_t'(min_hold);
            2: return time_t'(min_hold) + 1;
            3: return time_t'(max_hold) - 1;
            4: return time_t'(max_hold);
            5: return time_t'(max_hold) + 1;
            6: return time_t'($urandom);
            default: return time_t'($urandom_range(min_hold, max_hold));
        endcase
    endfunction

    task automatic send_poll(input poll_t p);
        if (src_idle_en)
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                poll_ch.valid <= 1'b0;
                @(posedge clk);
            end
        poll_ch.valid       <= 1'b1;
        poll_ch.now_ms      <= p.now;
        poll_ch.status_ok   <= p.status_ok;
        poll_ch.status_byte <= p.status;
        poll_ch.point_ok    <= p.point_ok;
        poll_ch.x_high      <= p.x_high;
        poll_ch.x_low       <= p.x_low;
        poll_ch.y_high      <= p.y_high;
        poll_ch.y_low       <= p.y_low;
        @(posedge clk);
        while (!poll_ch.ready)
            @(posedge clk);
        report_q.push_back(predict_poll(p));
    endtask

    task automatic send_touch(input time_t t, input coord_t x, input coord_t y);
        send_poll(make_poll(t, 1'b1, touch_status(), 1'b1, x, y));
    endtask

    task automatic send_lift(input time_t t);
        send_poll(make_poll(t, 1'b1, lift_status(), 1'($urandom), 12'($urandom), 12'($urandom)));
    endtask

    task automatic wait_for_results();
        poll_ch.valid <= 1'b0;
        @(posedge clk);
        while (report_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic quiesce();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_MIN_HOLD:  min_hold = data;
            REG_MAX_HOLD:  max_hold = data;
            REG_MAX_DRIFT: drift_limit = data[DRIFT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input hold_t lo, input hold_t hi, input logic [15:0] drift);
        quiesce();
        write_reg(REG_MIN_HOLD, lo);
        write_reg(REG_MAX_HOLD, hi);
        write_reg(REG_MAX_DRIFT, drift);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_press_sequences(input int count);
        time_t  t0;
        time_t  t;
        time_t  hold;
        coord_t x0;
        coord_t y0;
        int     moves;
        int     rad;
        int     kind;
        for (int s = 0; s < count; s++)
        begin
            x0 = 12'($urandom);
            y0 = 12'($urandom);
            t0 = clock_ms;
            if ($urandom_range(9) == 0)
                send_poll(make_poll(t0, 1'b0, 8'($urandom), 1'($urandom), x0, y0));
            else if ($urandom_range(9) == 0)
                send_poll(make_poll(t0, 1'b1, touch_status(), 1'b0, x0, y0));
            hold  = pick_hold();
            moves = $urandom_range(0, 5);
            rad   = int'(drift_limit) + 8;
            if (rad > COORD_MAX || $urandom_range(9) < 2)
                rad = COORD_MAX;
            send_touch(t0, x0, y0);
            for (int k = 1; k <= moves; k++)
            begin
                t    = t0 + time_t'((64'(hold) * k) / (moves + 1));
                kind = $urandom_range(9);
                if (kind == 0)
                    send_poll(make_poll(t, 1'b0, 8'($urandom), 1'($urandom),
                                        nudge(x0, rad), nudge(y0, rad)));
                else if (kind == 1)
                    send_poll(make_poll(t, 1'b1, touch_status(), 1'b0,
                                        nudge(x0, rad), nudge(y0, rad)));
                else
                    send_touch(t, nudge(x0, rad), nudge(y0, rad));
            end
            send_lift(t0 + hold);
            clock_ms = t0 + hold + $urandom_range(1, 200);
        end
    endtask

    task automatic test_directed_polls();
        send_poll(make_poll(32'd900, 1'b0, 8'h0F, 1'b1, 12'd100, 12'd100));
        send_poll(make_poll(32'd901, 1'b1, 8'hF1, 1'b0, 12'd100, 12'd100));
        send_poll(make_poll(32'd902, 1'b1, 8'hF0, 1'b1, 12'd100, 12'd100));
        send_touch(32'd1000, 12'hFFF, 12'hFFF);
        send_touch(32'd1005, 12'h000, 12'h000);
        send_poll(make_poll(32'd1006, 1'b0, 8'h00, 1'b1, 12'd0, 12'd0));
        send_poll(make_poll(32'd1007, 1'b1, 8'h01, 1'b0, 12'd0, 12'd0));
        send_lift(32'd1015);
        send_touch(32'd2000, 12'd100, 12'd100);
        send_touch(32'd2005, 12'd124, 12'd132);
        send_lift(32'd2015);
        send_touch(32'd3000, 12'd200, 12'd200);
        send_touch(32'd3005, 12'd241, 12'd200);
        send_lift(32'd3015);
        send_touch(32'd4000, 12'd300, 12'd300);
        send_lift(32'd4700);
        send_touch(32'd5000, 12'd300, 12'd300);
        send_lift(32'd5701);
        send_touch(32'd6000, 12'd300, 12'd300);
        send_lift(32'd6014);
        send_touch(32'hFFFF_FFF0, 12'd400, 12'd400);
        send_lift(32'h0000_0010);
    endtask

    task automatic test_register_settings();
        quiesce();
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_MAX_DRIFT, 16'hE000);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_touch(32'd7000, 12'd500, 12'd500);
        send_touch(32'd7005, 12'd501, 12'd500);
        send_lift(32'd7020);
        send_touch(32'd8000, 12'd500, 12'd500);
        send_touch(32'd8005, 12'd500, 12'd500);
        send_lift(32'd8020);
        apply_config(16'd0, 16'd0, 16'd40);
        send_touch(32'd9000, 12'd10, 12'd10);
        send_lift(32'd9000);
        send_touch(32'd9100, 12'd10, 12'd10);
        send_lift(32'd9101);
        apply_config(16'hFFFF, 16'hFFFF, 16'd5792);
        send_touch(32'd10000, 12'h000, 12'h000);
        send_touch(32'd10001, 12'hFFF, 12'hFFF);
        send_lift(32'd10000 + 32'd65535);
        send_touch(32'd80000, 12'h000, 12'h000);
        send_lift(32'd80000 + 32'd65534);
        apply_config(16'd500, 16'd100, 16'd100);
        send_touch(32'd200000, 12'd50, 12'd50);
        send_lift(32'd200300);
    endtask

    task automatic test_random_presses();
        apply_config(RST_MIN_HOLD, RST_MAX_HOLD, 16'(RST_MAX_DRIFT));
        clock_ms = $urandom;
        run_press_sequences(40);
        apply_config(16'd0, 16'hFFFF, 16'd5792);
        run_press_sequences(30);
        apply_config(16'hFFFF, 16'hFFFF, 16'd0);
        run_press_sequences(25);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        apply_config(16'($urandom_range(0, 100)), 16'($urandom_range(200, 2000)),
                     16'($urandom_range(0, 200)));
        run_press_sequences(40);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        apply_config(16'($urandom), 16'($urandom), 16'($urandom_range(0, 5792)));
        run_press_sequences(30);
    endtask

    task automatic test_back_pressure();
        apply_config(RST_MIN_HOLD, RST_MAX_HOLD, 16'(RST_MAX_DRIFT));
        sink_hold_req = 300;
        run_press_sequences(8);
        wait_for_results();
        run_press_sequences(4);
    endtask

    task automatic test_noise();
        for (int n = 0; n < 120; n++)
            send_poll(make_poll(time_t'($urandom), $urandom_range(9) != 0, 8'($urandom),
                                1'($urandom), 12'($urandom), 12'($urandom)));
    endtask

    // The receiver honors a requested hold-off before resuming random stalls.
    initial
    begin
        int hold_left;
        hold_left = 0;
        report_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req > 0)
            begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                report_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                report_ch.ready <= !(sink_idle_en && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        tap_report_t want;
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            if (report_q.size() == 0)
            begin
                if (errors < SHOW_LIMIT)
                    $display("unexpected transaction: tap=%0b pressed=%0b",
                             report_ch.tap, report_ch.pressed);
                errors++;
            end
            else
            begin
                want = report_q.pop_front();
                if (report_ch.tap !== want.tap || report_ch.pressed !== want.pressed)
                begin
                    if (errors < SHOW_LIMIT)
                        $display("mismatch: expected tap=%0b pressed=%0b, got tap=%0b pressed=%0b",
                                 want.tap, want.pressed, report_ch.tap, report_ch.pressed);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((poll_ch.valid && poll_ch.ready) || (report_ch.valid && report_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_MIN_HOLD;
        cfg_wdata           <= '0;
        poll_ch.valid       <= 1'b0;
        poll_ch.now_ms      <= '0;
        poll_ch.status_ok   <= 1'b0;
        poll_ch.status_byte <= '0;
        poll_ch.point_ok    <= 1'b0;
        poll_ch.x_high      <= '0;
        poll_ch.x_low       <= '0;
        poll_ch.y_high      <= '0;
        poll_ch.y_low       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_polls();
        test_register_settings();
        test_random_presses();
        test_back_pressure();
        test_noise();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && report_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
